>>> design/rmq_pkg.sv
// shared types, constants and handshake structs for the range mode query engine
// depends on nothing; used by rmq_ctrl, rmq_datapath and range_mode_query_engine
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int MAX_ITEMS  = 4096;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int NODE_W     = IDX_W + 1;
    localparam int LVL_W      = $clog2(IDX_W + 1);

    localparam logic [1:0] OP_NEW    = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_BAD_RANGE = 2'd2;
    localparam logic [1:0] ST_NO_DATA   = 2'd3;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [31:0] value;
        logic [11:0]        left_index;
        logic [11:0]        right_index;
    } t_in_item;

    typedef struct packed {
        logic [12:0] frequency;
        logic [1:0]  status;
    } t_out_item;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic decode;
        logic do_new;
        logic do_append;
        logic up_rd;
        logic up_wr;
        logic q_calc;
        logic t_acc;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       dec_err;
        logic       is_root;
        logic       need_tree;
        logic       l_lt_r;
    } t_stat;

endpackage

>>> design/rmq_ctrl.sv
// controller state machine of the range mode query engine
// depends on rmq_pkg for the command and status structs
`timescale 1ns / 1ps

module rmq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  rmq_pkg::t_stat i_stat,
    output rmq_pkg::t_cmd  o_cmd,
    output logic          busy,
    output logic          o_valid
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_UP_RD  = 9'b000000100,
        S_UP_WR  = 9'b000001000,
        S_Q_EDGE = 9'b000010000,
        S_T_RD   = 9'b000100000,
        S_T_ACC  = 9'b001000000,
        S_DONE   = 9'b010000000,
        S_SPARE  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.decode = 1'b1;
                case (i_stat.op)
                    rmq_pkg::OP_NEW: begin
                        o_cmd.do_new = 1'b1;
                        n_state      = S_UP_RD;
                    end
                    rmq_pkg::OP_APPEND: begin
                        if (i_stat.dec_err) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd.do_append = 1'b1;
                            n_state         = S_UP_RD;
                        end
                    end
                    rmq_pkg::OP_QUERY: begin
                        n_state = i_stat.dec_err ? S_DONE : S_Q_EDGE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_UP_RD: begin
                o_cmd.up_rd = 1'b1;
                n_state     = i_stat.is_root ? S_DONE : S_UP_WR;
            end
            S_UP_WR: begin
                o_cmd.up_wr = 1'b1;
                n_state     = S_UP_RD;
            end
            S_Q_EDGE: begin
                o_cmd.q_calc = 1'b1;
                n_state      = i_stat.need_tree ? S_T_RD : S_DONE;
            end
            S_T_RD: begin
                n_state = i_stat.l_lt_r ? S_T_ACC : S_DONE;
            end
            S_T_ACC: begin
                o_cmd.t_acc = 1'b1;
                n_state     = S_T_RD;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

>>> design/rmq_datapath.sv
// datapath of the range mode query engine: counters, run stores and max-tree memory
// depends on rmq_pkg for widths, codes and the command and status structs
`timescale 1ns / 1ps

module rmq_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rmq_pkg::t_in_item i_in,
    input  rmq_pkg::t_cmd     i_cmd,
    output rmq_pkg::t_stat    o_stat,
    output rmq_pkg::t_out_item o_result
);

    localparam int IW = rmq_pkg::IDX_W;
    localparam int CW = rmq_pkg::CNT_W;
    localparam int NW = rmq_pkg::NODE_W;
    localparam int LW = rmq_pkg::LVL_W;
    localparam logic [NW-1:0] LEAF_BASE = NW'(rmq_pkg::MAX_ITEMS);

    // control state
    logic [CW-1:0] r_item_count, r_run_count;
    // payload state
    rmq_pkg::t_in_item            r_in;
    logic [rmq_pkg::VALUE_BITS-1:0] r_last_value;
    logic [IW-1:0] r_last_start, r_ra, r_rb;
    logic [NW-1:0] r_node, r_l, r_r;
    logic [CW-1:0] r_cur, r_freq;
    logic [LW-1:0] r_lvl;
    logic [1:0]    r_status;

    // memories
    logic [IW-1:0] mem_roi [rmq_pkg::MAX_ITEMS];
    logic [IW-1:0] mem_rs  [rmq_pkg::MAX_ITEMS];
    logic [IW-1:0] mem_re  [rmq_pkg::MAX_ITEMS];
    logic [CW-1:0] mem_tree[2*rmq_pkg::MAX_ITEMS];
    logic [IW-1:0] rd_roi_a, rd_roi_b, rd_rs, rd_re;
    logic [CW-1:0] rd_t_a, rd_t_b;

    logic [IW-1:0] li, ri, roi_addr_a, roi_addr_b, pos, run_idx;
    logic          is_new, wr_load;
    logic [CW-1:0] len, sib_val, parent, q_freq, edge_a, edge_b, best;
    logic [NW-1:0] sib, sib_shift, t_addr_a, t_wa, leaf_node;
    logic [CW-1:0] t_wd;
    logic [1:0]    code;

    assign li = r_in.left_index[IW-1:0];
    assign ri = r_in.right_index[IW-1:0];

    // decode of error codes
    always_comb begin
        code = rmq_pkg::ST_OK;
        case (r_in.opcode)
            rmq_pkg::OP_APPEND: begin
                if (r_item_count == '0) begin
                    code = rmq_pkg::ST_NO_DATA;
                end else if (r_item_count >= CW'(rmq_pkg::MAX_ITEMS)) begin
                    code = rmq_pkg::ST_FULL;
                end
            end
            rmq_pkg::OP_QUERY: begin
                if (r_item_count == '0) begin
                    code = rmq_pkg::ST_NO_DATA;
                end else if (li > ri || CW'(ri) >= r_item_count) begin
                    code = rmq_pkg::ST_BAD_RANGE;
                end
            end
            default: begin
                code = rmq_pkg::ST_OK;
            end
        endcase
    end

    // append bookkeeping
    assign pos     = r_item_count[IW-1:0];
    assign is_new  = (r_in.value[rmq_pkg::VALUE_BITS-1:0] != r_last_value);
    assign run_idx = i_cmd.do_new ? '0
                   : (is_new ? r_run_count[IW-1:0] : r_run_count[IW-1:0] - 1'b1);
    assign len     = is_new ? CW'(1) : (CW'(pos) - CW'(r_last_start) + 1'b1);
    assign wr_load = i_cmd.do_new | i_cmd.do_append;
    assign leaf_node = LEAF_BASE | NW'(run_idx);

    // tree path update: sibling counts only if its leftmost leaf is a live run
    assign sib       = r_node ^ NW'(1);
    assign sib_shift = sib << r_lvl;
    assign sib_val   = (CW'(sib_shift[IW-1:0]) < r_run_count) ? rd_t_a : '0;
    assign parent    = (sib_val > r_cur) ? sib_val : r_cur;

    assign t_addr_a = i_cmd.up_rd ? sib : r_l;
    assign t_wa     = i_cmd.up_wr ? (r_node >> 1) : leaf_node;
    assign t_wd     = i_cmd.up_wr ? parent : (i_cmd.do_new ? CW'(1) : len);

    // query edges
    assign edge_a = CW'(rd_re) - CW'(li) + 1'b1;
    assign edge_b = CW'(ri) - CW'(rd_rs) + 1'b1;
    assign q_freq = (r_ra == r_rb) ? (CW'(ri) - CW'(li) + 1'b1)
                  : ((edge_a > edge_b) ? edge_a : edge_b);

    always_comb begin
        best = r_freq;
        if (r_l[0] && rd_t_a > best) begin
            best = rd_t_a;
        end
        if (r_r[0] && rd_t_b > best) begin
            best = rd_t_b;
        end
    end

    assign roi_addr_a = i_cmd.accept ? IW'(i_in.left_index)  : li;
    assign roi_addr_b = i_cmd.accept ? IW'(i_in.right_index) : ri;

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_new || (i_cmd.do_append && is_new)) begin
            mem_rs[run_idx] <= pos & {IW{i_cmd.do_append}};
        end
        rd_rs <= mem_rs[rd_roi_b];
    end

    always_ff @(posedge i_clk) begin
        if (wr_load) begin
            mem_re[run_idx] <= pos & {IW{i_cmd.do_append}};
        end
        rd_re <= mem_re[rd_roi_a];
    end

    always_ff @(posedge i_clk) begin
        if (wr_load) begin
            mem_roi[pos & {IW{i_cmd.do_append}}] <= run_idx;
        end
        rd_roi_a <= mem_roi[roi_addr_a];
        rd_roi_b <= mem_roi[roi_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (wr_load || i_cmd.up_wr) begin
            mem_tree[t_wa] <= t_wd;
        end
        rd_t_a <= mem_tree[t_addr_a];
        rd_t_b <= mem_tree[r_r - 1'b1];
    end

    // counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= '0;
            r_run_count  <= '0;
        end else if (i_cmd.do_new) begin
            r_item_count <= CW'(1);
            r_run_count  <= CW'(1);
        end else if (i_cmd.do_append) begin
            r_item_count <= r_item_count + 1'b1;
            if (is_new) begin
                r_run_count <= r_run_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_value <= '0;
        end else if (wr_load) begin
            r_last_value <= r_in.value[rmq_pkg::VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_in;
        end
        if (i_cmd.do_new) begin
            r_last_start <= '0;
        end else if (i_cmd.do_append && is_new) begin
            r_last_start <= pos;
        end
        if (i_cmd.decode) begin
            r_freq   <= '0;
            r_status <= code;
            r_ra     <= rd_roi_a;
            r_rb     <= rd_roi_b;
        end else if (i_cmd.q_calc) begin
            r_freq <= q_freq;
        end else if (i_cmd.t_acc) begin
            r_freq <= best;
        end
        if (wr_load) begin
            r_node <= leaf_node;
            r_cur  <= t_wd;
            r_lvl  <= '0;
        end else if (i_cmd.up_wr) begin
            r_node <= r_node >> 1;
            r_cur  <= parent;
            r_lvl  <= r_lvl + 1'b1;
        end
        if (i_cmd.q_calc) begin
            r_l <= LEAF_BASE + NW'(r_ra) + 1'b1;
            r_r <= LEAF_BASE + NW'(r_rb);
        end else if (i_cmd.t_acc) begin
            r_l <= (r_l + NW'(r_l[0])) >> 1;
            r_r <= (r_r - NW'(r_r[0])) >> 1;
        end
    end

    assign o_stat.op        = r_in.opcode;
    assign o_stat.dec_err   = (code != rmq_pkg::ST_OK);
    assign o_stat.is_root   = (r_node == NW'(1));
    assign o_stat.need_tree = (CW'(r_ra) + 1'b1 < CW'(r_rb));
    assign o_stat.l_lt_r    = (r_l < r_r);

    assign o_result.frequency = r_freq;
    assign o_result.status    = r_status;

    a_runs_le_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run_count <= r_item_count)
        else $error("more runs than items");

    a_items_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_item_count <= CW'(rmq_pkg::MAX_ITEMS))
        else $error("item count beyond capacity");

endmodule

>>> design/range_mode_query_engine.sv
// top level of the range mode query engine: controller plus datapath
// depends on rmq_pkg, rmq_ctrl and rmq_datapath
`timescale 1ns / 1ps

// command-style block: an item is taken when start is high and busy is low, and
// exactly one result comes back per item, shown for a single cycle with o_valid;
// the receiver cannot stall it, so it must take the result in that cycle.
// opcode 0 starts a new array with value, 1 appends value, 2 asks for the highest
// count of one value over positions left_index..right_index (0-based, inclusive).
// loads rewrite the run-length max-tree path one level at a time, a read and then
// a write per level, through one tree write port. queries finish after the edge
// step when both ends sit in one run or no whole run lies between them; otherwise
// they walk the tree, reading two tree nodes per level from the registered tree
// memory. errors and the unused opcode go from decode straight to the result.
// no clearing pass: stale tree nodes from an earlier array are masked out by
// comparing against the current run count

module range_mode_query_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  rmq_pkg::t_in_item  i_in,
    output logic               busy,
    output logic               o_valid,
    output rmq_pkg::t_out_item o_result
);

    rmq_pkg::t_cmd  cmd;
    rmq_pkg::t_stat stat;

    // sequencing of decode, tree path update and tree walk
    rmq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    // counters, run stores and the max-tree memory
    rmq_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result)
    );

    // a transfer in always leads into a busy period
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");

    // result strobe comes at the end of the busy period and is single-cycle
    a_valid_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> (!busy && !o_valid))
        else $error("result strobe not followed by idle");

    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> busy)
        else $error("result strobe outside busy period");

endmodule
